FILE: hdl/edmf_pkg.sv
// shared types and constants of the echo distance median filter
`timescale 1ns / 1ps
`default_nettype none

package edmf_pkg;

  // operation codes
  localparam logic [1:0] OP_MEASURE = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_READ    = 2'd2;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned OVF_W   = 4;
  localparam int unsigned TIME_W  = TICK_W + OVF_W;
  localparam int unsigned DIST_W  = 15;

  // distance = ticks * 343 / 20000, the division done as a reciprocal multiply
  localparam int unsigned SOUND_W   = 9;
  localparam logic [SOUND_W-1:0] SOUND_MUL = 9'd343;
  localparam int unsigned PROD_W    = TIME_W + SOUND_W;
  localparam int unsigned RECIP_W   = 30;
  localparam logic [RECIP_W-1:0] RECIP_MUL = 30'd879609303;
  localparam int unsigned RECIP_SHIFT = 44;
  localparam int unsigned SCALED_W  = PROD_W + RECIP_W;

  // largest distance a 20 bit echo time can give
  localparam logic [DIST_W-1:0] DIST_MAX = 15'd17983;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DIST_W-1:0] distance;
  } edmf_cmd_t;

endpackage

`default_nettype wire

FILE: hdl/echo_distance_median_filter.sv
// top level of the echo distance median filter
`timescale 1ns / 1ps
`default_nettype none

// each transfer in gives exactly one transfer out, in order. a measure item
// turns start tick, end tick and wrap count into an echo time (negative
// saturates to 0) and a distance in cm, time*343/20000, and stores it in a
// ring of SAMPLES_PER_MEDIAN slots; writing the last slot sorts the ring and
// stores its median (mean of the two middle entries for an even count) and
// raises new_ready. start clears the slot index and the median, read clears
// new_ready. the front end is a pipeline (echo time, multiply by 343,
// reciprocal multiply for the division) feeding a two entry command queue.
// the back end takes one command per cycle, while the output is not stalled,
// for items that do not complete a set; a set-completing measure holds it
// for SAMPLES_PER_MEDIAN sort passes, one odd-even transposition pass per
// cycle, and then until its result can be loaded into the output register.
// the queue lets inputs keep flowing while a result waits on out_stall_i.
module echo_distance_median_filter #(
  parameter int unsigned SAMPLES_PER_MEDIAN = 5
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [1:0]  operation_i,
  input  wire  [15:0] echo_start_tick_i,
  input  wire  [15:0] echo_end_tick_i,
  input  wire  [3:0]  overflow_count_i,
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [14:0] median_distance_o,
  output logic [14:0] fresh_distance_o,
  output logic        new_ready_o,
  output logic        set_complete_o
);
  import edmf_pkg::*;

  // front to queue
  logic      push;
  edmf_cmd_t push_cmd;
  logic      full;
  // queue to back
  logic      pop;
  edmf_cmd_t pop_cmd;
  logic      empty;

  edmf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .echo_start_tick_i (echo_start_tick_i),
    .echo_end_tick_i   (echo_end_tick_i),
    .overflow_count_i  (overflow_count_i),
    .push_o            (push),
    .push_cmd_o        (push_cmd),
    .full_i            (full)
  );

  edmf_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (full),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .empty_o    (empty)
  );

  edmf_back #(
    .SAMPLES_PER_MEDIAN (SAMPLES_PER_MEDIAN)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .empty_i           (empty),
    .cmd_i             (pop_cmd),
    .pop_o             (pop),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .median_distance_o (median_distance_o),
    .fresh_distance_o  (fresh_distance_o),
    .new_ready_o       (new_ready_o),
    .set_complete_o    (set_complete_o)
  );

  // the queue must never take a push while full or give a pop while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(push && full))
    else $error("push into full command queue");

  assert property (@(posedge clk_i) disable iff (!rst_ni) !(pop && empty))
    else $error("pop from empty command queue");

  // a completed set always leaves an unread median
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && set_complete_o |-> new_ready_o)
    else $error("set complete without unread median");

  // distances cannot exceed what a 20 bit echo time produces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (fresh_distance_o <= DIST_MAX) && (median_distance_o <= DIST_MAX))
    else $error("distance out of range");

endmodule

`default_nettype wire

FILE: hdl/edmf_front.sv
// front end: takes items, forms echo time and distance, pushes commands
`timescale 1ns / 1ps
`default_nettype none

module edmf_front (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  output logic                             in_stall_o,
  input  wire  [1:0]                       operation_i,
  input  wire  [15:0]                      echo_start_tick_i,
  input  wire  [15:0]                      echo_end_tick_i,
  input  wire  [3:0]                       overflow_count_i,
  output logic                             push_o,
  output edmf_pkg::edmf_cmd_t              push_cmd_o,
  input  wire                              full_i
);
  import edmf_pkg::*;

  logic                s1_valid_q, s1_valid_d;
  logic [OP_W-1:0]     s1_op_q;
  logic [TIME_W-1:0]   s1_ticks_q;
  logic                s2_valid_q, s2_valid_d;
  logic [OP_W-1:0]     s2_op_q;
  logic [PROD_W-1:0]   s2_prod_q;

  logic [TIME_W-1:0]   total;
  logic [TIME_W:0]     diff;
  logic [TIME_W-1:0]   ticks;
  logic [PROD_W-1:0]   prod;
  logic [SCALED_W-1:0] scaled;
  logic                in_take, s1_move, s2_move;

  // echo time with negative values saturated to zero
  assign total = {overflow_count_i, echo_end_tick_i};
  assign diff  = {1'b0, total} - {{(OVF_W + 1){1'b0}}, echo_start_tick_i};
  always_comb begin
    ticks = '0;
    if (operation_i == OP_MEASURE && !diff[TIME_W]) begin
      ticks = diff[TIME_W-1:0];
    end
  end

  assign prod   = {{SOUND_W{1'b0}}, s1_ticks_q} * {{TIME_W{1'b0}}, SOUND_MUL};
  assign scaled = {{RECIP_W{1'b0}}, s2_prod_q} * {{PROD_W{1'b0}}, RECIP_MUL};

  assign s2_move    = s2_valid_q && !full_i;
  assign s1_move    = s1_valid_q && (!s2_valid_q || s2_move);
  assign in_stall_o = s1_valid_q && !s1_move;
  assign in_take    = in_valid_i && !in_stall_o;

  assign s1_valid_d = in_take || (s1_valid_q && !s1_move);
  assign s2_valid_d = s1_move || (s2_valid_q && !s2_move);

  assign push_o              = s2_move;
  assign push_cmd_o.op       = s2_op_q;
  assign push_cmd_o.distance = scaled[RECIP_SHIFT +: DIST_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s2_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_op_q    <= operation_i;
      s1_ticks_q <= ticks;
    end
    if (s1_move) begin
      s2_op_q   <= s1_op_q;
      s2_prod_q <= prod;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/edmf_queue.sv
// small command queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module edmf_queue (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  edmf_pkg::edmf_cmd_t  push_cmd_i,
  output logic                 full_o,
  input  wire                  pop_i,
  output edmf_pkg::edmf_cmd_t  pop_cmd_o,
  output logic                 empty_o
);
  import edmf_pkg::*;

  edmf_cmd_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q, count_d;

  assign full_o    = count_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o   = count_q == '0;
  assign pop_cmd_o = slot_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/edmf_back.sv
// back end: ring, transposition sort, median and result register
`timescale 1ns / 1ps
`default_nettype none

module edmf_back #(
  parameter int unsigned SAMPLES_PER_MEDIAN = 5
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  empty_i,
  input  edmf_pkg::edmf_cmd_t  cmd_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic [14:0]          median_distance_o,
  output logic [14:0]          fresh_distance_o,
  output logic                 new_ready_o,
  output logic                 set_complete_o
);
  import edmf_pkg::*;

  localparam int unsigned N      = SAMPLES_PER_MEDIAN;
  localparam int unsigned IDX_W  = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned PASS_W = $clog2(N + 1);
  localparam int unsigned LO_IDX = (N % 2 == 0) ? N / 2 - 1 : N / 2;
  localparam int unsigned HI_IDX = N / 2;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [DIST_W-1:0] ring_q [N];
  logic [DIST_W-1:0] ring_d [N];
  logic [DIST_W-1:0] sorted [N];
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [PASS_W-1:0] pass_q, pass_d;
  logic [DIST_W-1:0] median_q, median_d;
  logic              flag_q, flag_d;
  logic [DIST_W-1:0] sample_q, sample_d;
  logic              out_valid_q, out_valid_d;
  logic [DIST_W-1:0] out_fresh_q, out_fresh_d;
  logic              out_complete_q, out_complete_d;
  logic              out_free, out_load;
  logic [DIST_W:0]   mid_sum;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !empty_i && out_free;
  assign mid_sum  = {1'b0, ring_q[LO_IDX]} + {1'b0, ring_q[HI_IDX]};

  // one odd-even transposition pass, pairs chosen by pass parity
  always_comb begin
    sorted = ring_q;
    for (int i = 0; i < int'(N) - 1; i++) begin
      if ((i % 2) == int'(pass_q[0]) && ring_q[i] > ring_q[i+1]) begin
        sorted[i]   = ring_q[i+1];
        sorted[i+1] = ring_q[i];
      end
    end
  end

  always_comb begin
    state_d        = state_q;
    ring_d         = ring_q;
    idx_d          = idx_q;
    pass_d         = pass_q;
    median_d       = median_q;
    flag_d         = flag_q;
    sample_d       = sample_q;
    out_load       = 1'b0;
    out_fresh_d    = out_fresh_q;
    out_complete_d = out_complete_q;
    case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          out_fresh_d    = '0;
          out_complete_d = 1'b0;
          case (cmd_i.op)
            OP_MEASURE: begin
              ring_d[idx_q] = cmd_i.distance;
              if (idx_q == IDX_W'(N - 1)) begin
                sample_d = cmd_i.distance;
                pass_d   = '0;
                state_d  = ST_SORT;
              end else begin
                idx_d       = idx_q + 1'b1;
                out_fresh_d = cmd_i.distance;
                out_load    = 1'b1;
              end
            end
            OP_START: begin
              idx_d    = '0;
              median_d = '0;
              out_load = 1'b1;
            end
            OP_READ: begin
              flag_d   = 1'b0;
              out_load = 1'b1;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      ST_SORT: begin
        ring_d = sorted;
        pass_d = pass_q + 1'b1;
        if (pass_q == PASS_W'(N - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          median_d       = mid_sum[DIST_W:1];
          flag_d         = 1'b1;
          idx_d          = '0;
          out_fresh_d    = sample_q;
          out_complete_d = 1'b1;
          out_load       = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      pass_q      <= '0;
      median_q    <= '0;
      flag_q      <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < int'(N); i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pass_q      <= pass_d;
      median_q    <= median_d;
      flag_q      <= flag_d;
      out_valid_q <= out_valid_d;
      ring_q      <= ring_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
    if (out_load) begin
      out_fresh_q    <= out_fresh_d;
      out_complete_q <= out_complete_d;
    end
  end

  // median and flag change only together with a result load
  assign out_valid_o       = out_valid_q;
  assign median_distance_o = median_q;
  assign new_ready_o       = flag_q;
  assign fresh_distance_o  = out_fresh_q;
  assign set_complete_o    = out_complete_q;

endmodule

`default_nettype wire

FILE: dv/tb_echo_distance_median_filter.sv
// testbench of the echo distance median filter: scoreboard, drivers and monitors
`timescale 1ns / 1ps

module tb_echo_distance_median_filter;
  import edmf_pkg::*;

  localparam int unsigned SAMPLES        = 5;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int unsigned ITEMS_PER_PHASE = 500;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned DRAIN_CYCLES   = 40;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned REPORT_LIMIT   = 10;

  // one result transfer as the block presents it
  typedef struct packed {
    logic [DIST_W-1:0] median;
    logic [DIST_W-1:0] fresh;
    logic              ready;
    logic              complete;
  } distance_result_t;

  // mirrors the filter state and keeps the results still owed by the block
  class median_scoreboard;
    logic [DIST_W-1:0] ring [SAMPLES];
    int unsigned       slot;
    logic [DIST_W-1:0] median;
    logic              unread;
    distance_result_t  owed_results [$];
    int unsigned       mismatches;
    int unsigned       n_items, n_sets, n_reads, n_starts, n_unused, n_negative, n_checked;

    function new();
      foreach (ring[i]) ring[i] = '0;
      slot       = 0;
      median     = '0;
      unread     = 1'b0;
      mismatches = 0;
      n_items = 0; n_sets = 0; n_reads = 0; n_starts = 0;
      n_unused = 0; n_negative = 0; n_checked = 0;
    endfunction

    function int unsigned pending();
      return owed_results.size();
    endfunction

    // echo time with wraps, saturated at zero, scaled to centimetres
    function logic [DIST_W-1:0] echo_distance_cm(logic [TICK_W-1:0] s, logic [TICK_W-1:0] e,
                                                 logic [OVF_W-1:0] o);
      logic [TIME_W-1:0] total;
      longint unsigned   ticks;
      total = {o, e};
      if (total >= TIME_W'(s)) ticks = longint'(total - TIME_W'(s));
      else begin
        ticks = 0;
        n_negative++;
      end
      return DIST_W'((ticks * 343) / 20000);
    endfunction

    // ascending insertion sort of the whole ring, in place
    function void sort_ring();
      logic [DIST_W-1:0] key;
      int                j;
      for (int i = 1; i < SAMPLES; i++) begin
        key = ring[i];
        j   = i;
        while (j > 0 && ring[j-1] > key) begin
          ring[j] = ring[j-1];
          j--;
        end
        ring[j] = key;
      end
    endfunction

    function void note_echo_item(logic [1:0] op, logic [TICK_W-1:0] s, logic [TICK_W-1:0] e,
                                 logic [OVF_W-1:0] o);
      distance_result_t want;
      int unsigned      lo, hi;
      want = '0;
      n_items++;
      case (op)
        OP_MEASURE: begin
          if (slot >= SAMPLES) slot = 0;
          want.fresh = echo_distance_cm(s, e, o);
          ring[slot] = want.fresh;
          if (slot == SAMPLES - 1) begin
            sort_ring();
            if (SAMPLES % 2 == 0) begin
              lo     = ring[SAMPLES/2 - 1];
              hi     = ring[SAMPLES/2];
              median = DIST_W'((lo + hi) / 2);
            end else begin
              median = ring[SAMPLES/2];
            end
            unread        = 1'b1;
            want.complete = 1'b1;
            slot          = 0;
            n_sets++;
          end else begin
            slot++;
          end
        end
        OP_START: begin
          slot   = 0;
          median = '0;
          n_starts++;
        end
        OP_READ: begin
          unread = 1'b0;
          n_reads++;
        end
        default: n_unused++;
      endcase
      want.median = median;
      want.ready  = unread;
      owed_results.push_back(want);
    endfunction

    function void report(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
        $display("mismatch on %s at %0t: expected %0d, actual %0d", what, $realtime, want, got);
    endfunction

    function void check_result(distance_result_t got);
      distance_result_t want;
      n_checked++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result at %0t: median %0d fresh %0d ready %0b complete %0b",
                   $realtime, got.median, got.fresh, got.ready, got.complete);
        return;
      end
      want = owed_results.pop_front();
      if (got.median !== want.median)     report("median_distance", want.median, got.median);
      if (got.fresh !== want.fresh)       report("fresh_distance", want.fresh, got.fresh);
      if (got.ready !== want.ready)       report("new_ready", want.ready, got.ready);
      if (got.complete !== want.complete) report("set_complete", want.complete, got.complete);
    endfunction
  endclass

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid    = 1'b0;
  logic [1:0]          operation   = OP_MEASURE;
  logic [TICK_W-1:0]   start_tick  = '0;
  logic [TICK_W-1:0]   end_tick    = '0;
  logic [OVF_W-1:0]    wrap_count  = '0;
  logic                out_stall   = 1'b0;
  logic                hold_active = 1'b0;
  logic                in_stall;
  logic                out_valid;
  logic [DIST_W-1:0]   median_distance;
  logic [DIST_W-1:0]   fresh_distance;
  logic                new_ready;
  logic                set_complete;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  median_scoreboard board = new();

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  echo_distance_median_filter #(
    .SAMPLES_PER_MEDIAN(SAMPLES)
  ) u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (operation),
    .echo_start_tick_i(start_tick),
    .echo_end_tick_i  (end_tick),
    .overflow_count_i (wrap_count),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .median_distance_o(median_distance),
    .fresh_distance_o (fresh_distance),
    .new_ready_o      (new_ready),
    .set_complete_o   (set_complete)
  );

  // receiver: random stall, forced high while a long hold-off runs
  always @(posedge clk_i) begin
    out_stall <= hold_active || ($urandom_range(0, 99) < recv_idle_pct);
  end

  // every output transfer is checked against the oldest owed result
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && !out_stall)
      board.check_result({median_distance, fresh_distance, new_ready, set_complete});
  end

  // watchdog: ends the run after too many cycles without any transfer
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results still owed",
             WATCHDOG_LIMIT, board.pending());
    $display("== FAIL ==");
    $finish;
  end

  // one input transfer; random idle cycles first, then hold until accepted
  task automatic send_item(input logic [1:0] op, input logic [TICK_W-1:0] s,
                           input logic [TICK_W-1:0] e, input logic [OVF_W-1:0] o);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    operation  <= op;
    start_tick <= s;
    end_tick   <= e;
    wrap_count <= o;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    board.note_echo_item(op, s, e, o);
  endtask

  // measure with random ticks; wrap count often small so negative times show up
  task automatic send_random_measure();
    logic [TICK_W-1:0] s, e;
    logic [OVF_W-1:0]  o;
    s = TICK_W'($urandom);
    e = TICK_W'($urandom);
    case ($urandom_range(0, 3))
      0:       o = '0;
      1:       o = OVF_W'($urandom_range(0, 2));
      default: o = OVF_W'($urandom);
    endcase
    send_item(OP_MEASURE, s, e, o);
  endtask

  task automatic send_random_noise(input logic [1:0] op);
    send_item(op, TICK_W'($urandom), TICK_W'($urandom), OVF_W'($urandom));
  endtask

  // sender goes quiet until the block has delivered everything it owes
  task automatic wait_all_results();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_item(OP_START, '0, '0, '0);
    // zero time, largest time, negative time, start equal to end, one tick
    send_item(OP_MEASURE, 16'h0000, 16'h0000, 4'h0);
    send_item(OP_MEASURE, 16'h0000, 16'hFFFF, 4'hF);
    send_item(OP_MEASURE, 16'hFFFF, 16'h0000, 4'h0);
    send_item(OP_MEASURE, 16'h1234, 16'h1234, 4'h0);
    send_item(OP_MEASURE, 16'hFFFF, 16'h0000, 4'h1);
    // read twice, the second with the flag already clear
    send_item(OP_READ, 16'hFFFF, 16'hFFFF, 4'hF);
    send_item(OP_READ, '0, '0, '0);
    send_item(OP_UNUSED, 16'hFFFF, 16'hFFFF, 4'hF);
    // partial set thrown away by a start
    send_item(OP_MEASURE, 16'h0000, 16'h8000, 4'h3);
    send_item(OP_MEASURE, 16'h0000, 16'h1000, 4'h0);
    send_item(OP_START, 16'hAAAA, 16'h5555, 4'hA);
    // descending distances, so the sort has work to do
    send_item(OP_MEASURE, 16'h0000, 16'hFFFF, 4'hF);
    send_item(OP_MEASURE, 16'h0000, 16'hFFFF, 4'h8);
    send_item(OP_MEASURE, 16'h0000, 16'hFFFF, 4'h4);
    send_item(OP_MEASURE, 16'h0000, 16'hFFFF, 4'h2);
    send_item(OP_MEASURE, 16'h0000, 16'hFFFF, 4'h1);
    send_item(OP_UNUSED, '0, '0, '0);
    // start keeps the unread flag but clears the median
    send_item(OP_START, 16'h5555, 16'hAAAA, 4'h5);
    send_item(OP_READ, '0, '0, '0);
  endtask

  // mostly whole sets of measures, some reads, starts and unused codes
  task automatic run_phase(input bit with_hold);
    int unsigned sent, pick;
    bit          hold_done;
    sent      = 0;
    hold_done = 1'b0;
    while (sent < ITEMS_PER_PHASE) begin
      if (with_hold && !hold_done && sent >= ITEMS_PER_PHASE / 3) begin
        hold_done = 1'b1;
        fork
          begin
            hold_active <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk_i);
            hold_active <= 1'b0;
          end
        join_none
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        repeat (SAMPLES) send_random_measure();
        sent += SAMPLES;
        if ($urandom_range(0, 1) == 0) begin
          send_random_noise(OP_READ);
          sent++;
        end
      end else if (pick < 80) begin
        send_random_noise(OP_START);
        sent++;
      end else if (pick < 88) begin
        send_random_noise(OP_READ);
        sent++;
      end else if (pick < 93) begin
        send_random_noise(OP_UNUSED);
      end else begin
        send_random_measure();
        sent++;
      end
    end
  endtask

  initial begin : main
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_all_results();

    send_idle_pct = 35;
    recv_idle_pct = 68;
    run_phase(1'b0);
    wait_all_results();

    send_idle_pct = 68;
    recv_idle_pct = 35;
    run_phase(1'b0);
    wait_all_results();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(1'b1);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (board.pending() != 0) begin
      board.mismatches++;
      $display("%0d results never arrived", board.pending());
    end
    $display("covered %0d input transfers: %0d completed sets, %0d starts, %0d reads",
             board.n_items, board.n_sets, board.n_starts, board.n_reads);
    $display("also %0d unused codes and %0d negative echo times; %0d results, %0d mismatches",
             board.n_unused, board.n_negative, board.n_checked, board.mismatches);
    if (board.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

FILE: echo_distance_median_filter.f
hdl/edmf_pkg.sv
hdl/edmf_front.sv
hdl/edmf_queue.sv
hdl/edmf_back.sv
hdl/echo_distance_median_filter.sv
dv/tb_echo_distance_median_filter.sv
